FILE: rtl/mi3_pkg.sv
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef logic [3:0] idx_t;

  // cofactor k = m[CA]*m[CB] - m[CC]*m[CD], sign folded into the order
  localparam idx_t CA [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam idx_t CB [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam idx_t CC [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam idx_t CD [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

endpackage

FILE: rtl/mi3_cofactor.sv
module mi3_cofactor #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  logic signed [ELEM_WIDTH-1:0] m [9],
  output logic signed [2*ELEM_WIDTH:0] cof [9],
  output logic signed [ELEM_WIDTH-1:0] row0 [3]
);
  import mi3_pkg::*;

  localparam int E = ELEM_WIDTH;

  logic signed [2*E-1:0] pa [9];
  logic signed [2*E-1:0] pb [9];
  logic signed [E-1:0]   r0a [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 9; k++) begin
        pa[k] <= m[CA[k]] * m[CB[k]];
        pb[k] <= m[CC[k]] * m[CD[k]];
      end
      for (int j = 0; j < 3; j++) r0a[j] <= m[j];
    end
    if (en[1]) begin
      for (int k = 0; k < 9; k++) cof[k] <= (2*E+1)'(pa[k]) - (2*E+1)'(pb[k]);
      for (int j = 0; j < 3; j++) row0[j] <= r0a[j];
    end
  end

endmodule

FILE: rtl/mi3_det.sv
module mi3_det #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                           clk,
  input  logic [2:0]                     en,
  input  logic signed [2*ELEM_WIDTH:0]   cof [9],
  input  logic signed [ELEM_WIDTH-1:0]   row0 [3],
  output logic signed [2*ELEM_WIDTH:0]   cof_d [9],
  output logic signed [3*ELEM_WIDTH+3:0] det
);
  import mi3_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int CW = 2*E+1;
  localparam int DW = 3*E+4;

  logic signed [2*E:0]   plo [3];
  logic signed [2*E:0]   phi [3];
  logic signed [DW-1:0]  term [3];
  logic signed [CW-1:0]  c2 [9];
  logic signed [CW-1:0]  c3 [9];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= row0[j] * $signed({1'b0, cof[j][E-1:0]});
        phi[j] <= row0[j] * $signed(cof[j][CW-1:E]);
      end
      c2 <= cof;
    end
    if (en[1]) begin
      for (int j = 0; j < 3; j++) term[j] <= (DW'(phi[j]) <<< E) + DW'(plo[j]);
      c3 <= c2;
    end
    if (en[2]) begin
      det   <= term[0] + term[1] + term[2];
      cof_d <= c3;
    end
  end

endmodule

FILE: rtl/mi3_div.sv
module mi3_div #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic [ELEM_WIDTH+4:0]          en,
  input  logic signed [2*ELEM_WIDTH:0]   cof [9],
  input  logic signed [3*ELEM_WIDTH+3:0] det,
  output logic signed [ELEM_WIDTH-1:0]   inv [9],
  output logic                           singular
);
  import mi3_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int CW = 2*E+1;
  localparam int DW = 3*E+4;
  localparam int NW = CW+2*FRAC_BITS+1;
  localparam int TW = NW-E-2;
  localparam int XW = (DW > TW) ? DW : TW;
  localparam int NQ = E+2;
  localparam logic [NQ-1:0] POS_LIM = {2'b00, {E{1'b1}}};
  localparam logic [NQ-1:0] NEG_LIM = {2'b01, {(E-1){1'b0}}, 1'b1};

  logic [CW-1:0] cmag [9];
  logic [8:0]    sgn5;
  logic [DW-1:0] dmag5;
  logic          zr5;

  logic [DW-1:0] rr [NQ+1][9];
  logic [NQ-1:0] nl [NQ+1][9];
  logic [NQ-1:0] qq [NQ+1][9];
  logic [8:0]    ov [NQ+1];
  logic [8:0]    ng [NQ+1];
  logic [DW-1:0] dd [NQ+1];
  logic          zz [NQ+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 9; k++) begin
        cmag[k] <= cof[k][CW-1] ? CW'(-cof[k]) : CW'(cof[k]);
        sgn5[k] <= cof[k][CW-1] ^ det[DW-1];
      end
      dmag5 <= det[DW-1] ? DW'(-det) : DW'(det);
      zr5   <= (det == '0);
    end
  end

  always_ff @(posedge clk) begin
    logic [NW-1:0] nfull;
    if (en[1]) begin
      for (int k = 0; k < 9; k++) begin
        nfull     = {cmag[k], {(2*FRAC_BITS+1){1'b0}}};
        ov[0][k] <= XW'(nfull[NW-1:E+2]) >= XW'(dmag5);
        rr[0][k] <= DW'(nfull[NW-1:E+2]);
        nl[0][k] <= nfull[E+1:0];
        qq[0][k] <= '0;
      end
      ng[0] <= sgn5;
      dd[0] <= dmag5;
      zz[0] <= zr5;
    end
  end

  for (genvar s = 0; s < NQ; s++) begin : g_iter
    always_ff @(posedge clk) begin
      logic [DW:0] rs;
      logic        ge;
      if (en[2+s]) begin
        for (int k = 0; k < 9; k++) begin
          rs = {rr[s][k], nl[s][k][NQ-1-s]};
          ge = rs >= {1'b0, dd[s]};
          rr[s+1][k] <= ge ? DW'(rs - {1'b0, dd[s]}) : rs[DW-1:0];
          qq[s+1][k] <= {qq[s][k][NQ-2:0], ge};
          nl[s+1][k] <= nl[s][k];
        end
        ov[s+1] <= ov[s];
        ng[s+1] <= ng[s];
        dd[s+1] <= dd[s];
        zz[s+1] <= zz[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [NQ-1:0] qr;
    if (en[E+4]) begin
      for (int k = 0; k < 9; k++) begin
        qr = (qq[NQ][k] + NQ'(1)) >> 1;
        if (zz[NQ]) begin
          inv[k] <= '0;
        end else if (!ng[NQ][k]) begin
          if (ov[NQ][k] || qq[NQ][k] >= POS_LIM) inv[k] <= {1'b0, {(E-1){1'b1}}};
          else inv[k] <= qr[E-1:0];
        end else begin
          if (ov[NQ][k] || qq[NQ][k] >= NEG_LIM) inv[k] <= {1'b1, {(E-1){1'b0}}};
          else inv[k] <= E'(-qr);
        end
      end
      singular <= zz[NQ];
    end
  end

endmodule

FILE: rtl/matrix_inverse_3x3_core.sv
// Throughput: one matrix per cycle when not stalled; the restoring
// divider retires one quotient bit per stage, ELEM_WIDTH+2 stages, nine lanes
// sharing the determinant.
// Bubbles collapse; a stalled result holds while earlier stages keep filling.
// Reset clears only the stage valid bits; data registers are not reset.
module matrix_inverse_3x3_core #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         ready,
  input  logic signed [ELEM_WIDTH-1:0] m00,
  input  logic signed [ELEM_WIDTH-1:0] m01,
  input  logic signed [ELEM_WIDTH-1:0] m02,
  input  logic signed [ELEM_WIDTH-1:0] m10,
  input  logic signed [ELEM_WIDTH-1:0] m11,
  input  logic signed [ELEM_WIDTH-1:0] m12,
  input  logic signed [ELEM_WIDTH-1:0] m20,
  input  logic signed [ELEM_WIDTH-1:0] m21,
  input  logic signed [ELEM_WIDTH-1:0] m22,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic signed [ELEM_WIDTH-1:0] inv00,
  output logic signed [ELEM_WIDTH-1:0] inv01,
  output logic signed [ELEM_WIDTH-1:0] inv02,
  output logic signed [ELEM_WIDTH-1:0] inv10,
  output logic signed [ELEM_WIDTH-1:0] inv11,
  output logic signed [ELEM_WIDTH-1:0] inv12,
  output logic signed [ELEM_WIDTH-1:0] inv20,
  output logic signed [ELEM_WIDTH-1:0] inv21,
  output logic signed [ELEM_WIDTH-1:0] inv22,
  output logic                         invertible
);
  import mi3_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int NS = E+10;

  logic [NS-1:0]         v;
  logic [NS-1:0]         en;
  logic signed [E-1:0]   m [9];
  logic signed [2*E:0]   cof [9];
  logic signed [2*E:0]   cof_d [9];
  logic signed [E-1:0]   row0 [3];
  logic signed [3*E+3:0] det;
  logic signed [E-1:0]   inv [9];
  logic                  singular;

  assign m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

  always_comb begin
    en[NS-1] = !v[NS-1] || res_ready;
    for (int k = NS-2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= valid;
      for (int k = 1; k < NS; k++) if (en[k]) v[k] <= v[k-1];
    end
  end

  mi3_cofactor #(.ELEM_WIDTH(E)) u_cof (
    .clk(clk), .en(en[1:0]), .m(m), .cof(cof), .row0(row0)
  );

  mi3_det #(.ELEM_WIDTH(E)) u_det (
    .clk(clk), .en(en[4:2]), .cof(cof), .row0(row0), .cof_d(cof_d), .det(det)
  );

  mi3_div #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en[NS-1:5]), .cof(cof_d), .det(det), .inv(inv), .singular(singular)
  );

  // inverse is the transposed cofactor matrix divided by the determinant
  assign ready      = en[0];
  assign res_valid  = v[NS-1];
  assign inv00      = inv[0];
  assign inv01      = inv[3];
  assign inv02      = inv[6];
  assign inv10      = inv[1];
  assign inv11      = inv[4];
  assign inv12      = inv[7];
  assign inv20      = inv[2];
  assign inv21      = inv[5];
  assign inv22      = inv[8];
  assign invertible = !singular;

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&v) && !res_ready |-> !ready)
    else $error("full pipeline accepted a beat while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat right after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !invertible |-> inv00 == '0 && inv11 == '0 && inv22 == '0 && inv01 == '0)
    else $error("singular matrix gave nonzero elements");

endmodule
